@@ rtl/bqeq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bqeq_pkg
// Shared types and constants of the biquad equaliser filter: coefficient
// widths, register indexes and reset values, and parameter defaults.
// ----------------------------------------------------------------------------
package bqeq_pkg;

  // coefficient and feedback history widths
  localparam int COEFF_W    = 32;
  localparam int Y_W        = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // defaults for the top level parameters
  localparam int DEF_NUM_CHANNELS    = 2;
  localparam int DEF_SAMPLE_BITS     = 24;
  localparam int DEF_COEFF_FRAC_BITS = 28;

  // coefficient register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } cfg_reg_e;

  // reset value of b0: unity gain in Q4.28
  localparam logic signed [COEFF_W-1:0] B0_RESET = 32'sh1000_0000;

  // one full coefficient set
  typedef struct packed {
    logic signed [COEFF_W-1:0] b0;
    logic signed [COEFF_W-1:0] b1;
    logic signed [COEFF_W-1:0] b2;
    logic signed [COEFF_W-1:0] a1;
    logic signed [COEFF_W-1:0] a2;
  } coef_set_t;

endpackage
`default_nettype wire

@@ rtl/bqeq_coef_regs.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bqeq_coef_regs
// Coefficient register bank, written through the plain configuration port.
// ----------------------------------------------------------------------------
module bqeq_coef_regs (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [bqeq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bqeq_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output bqeq_pkg::coef_set_t                     coef
);
  import bqeq_pkg::*;

  // unity b0, every other tap zero
  localparam coef_set_t COEF_RESET = {B0_RESET, {(4*COEFF_W){1'b0}}};

  coef_set_t coef_r;
  coef_set_t coef_nxt;

  // decode the register index, writes past the last register are dropped
  always_comb begin
    coef_nxt = coef_r;
    if (cfg_we) begin
      case (cfg_reg_e'(cfg_index))
        REG_B0:  coef_nxt.b0 = $signed(cfg_wdata[COEFF_W-1:0]);
        REG_B1:  coef_nxt.b1 = $signed(cfg_wdata[COEFF_W-1:0]);
        REG_B2:  coef_nxt.b2 = $signed(cfg_wdata[COEFF_W-1:0]);
        REG_A1:  coef_nxt.a1 = $signed(cfg_wdata[COEFF_W-1:0]);
        REG_A2:  coef_nxt.a2 = $signed(cfg_wdata[COEFF_W-1:0]);
        default: coef_nxt = coef_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= COEF_RESET;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  assign coef = coef_r;

endmodule
`default_nettype wire

@@ rtl/bqeq_hist_mem.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bqeq_hist_mem
// Per-channel history memory: one write and one read port, registered read
// data, write-first on a same-address collision, per-entry valid bits so an
// entry never written since reset reads as zero.
// ----------------------------------------------------------------------------
module bqeq_hist_mem #(
  parameter int DEPTH = 2,
  parameter int AW    = 1,
  parameter int DW    = 112
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata
);
  import bqeq_pkg::*;

  logic [DW-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [DW-1:0] rdata_r;

  // storage array
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  // registered read with bypass of a write to the same entry
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata_r <= wdata;
      end else if (vld_r[raddr]) begin
        rdata_r <= mem[raddr];
      end else begin
        rdata_r <= '0;
      end
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ rtl/bqeq_mac.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bqeq_mac
// Five-tap multiply stage with registered products, then the exact sum,
// round half up, 32-bit feedback saturation and output saturation.
// ----------------------------------------------------------------------------
module bqeq_mac #(
  parameter int SAMPLE_BITS     = 24,
  parameter int COEFF_FRAC_BITS = 28
) (
  input  wire logic                           clk,
  input  wire logic                           en,
  input  wire bqeq_pkg::coef_set_t            coef,
  input  wire logic signed [SAMPLE_BITS-1:0]  x0,
  input  wire logic signed [SAMPLE_BITS-1:0]  x1,
  input  wire logic signed [SAMPLE_BITS-1:0]  x2,
  input  wire logic signed [bqeq_pkg::Y_W-1:0] y1,
  input  wire logic signed [bqeq_pkg::Y_W-1:0] y2,
  output logic      signed [bqeq_pkg::Y_W-1:0] y_fb,
  output logic      signed [SAMPLE_BITS-1:0]  y_out,
  output logic                                clip
);
  import bqeq_pkg::*;

  localparam int PX_W  = COEFF_W + SAMPLE_BITS;
  localparam int PY_W  = COEFF_W + Y_W;
  localparam int ACC_W = PY_W + 3;

  localparam logic signed [ACC_W-1:0] RND_HALF =
    {{(ACC_W-1){1'b0}}, 1'b1} << (COEFF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] Y_MAX_EXT = ACC_W'(64'sh7FFF_FFFF);
  localparam logic signed [ACC_W-1:0] Y_MIN_EXT = ~Y_MAX_EXT;
  localparam logic signed [Y_W-1:0]   OUT_MAX   =
    32'sh7FFF_FFFF >>> (Y_W - SAMPLE_BITS);
  localparam logic signed [Y_W-1:0]   OUT_MIN   = ~OUT_MAX;

  logic signed [PX_W-1:0] p0_r, p1_r, p2_r;
  logic signed [PY_W-1:0] p3_r, p4_r;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] q;

  // product registers
  always_ff @(posedge clk) begin
    if (en) begin
      p0_r <= coef.b0 * x0;
      p1_r <= coef.b1 * x1;
      p2_r <= coef.b2 * x2;
      p3_r <= coef.a1 * y1;
      p4_r <= coef.a2 * y2;
    end
  end

  // exact sum with rounding offset, then drop the fraction
  always_comb begin
    acc = ACC_W'(p0_r) + ACC_W'(p1_r) + ACC_W'(p2_r)
        - ACC_W'(p3_r) - ACC_W'(p4_r) + RND_HALF;
    q   = acc >>> COEFF_FRAC_BITS;
  end

  // feedback saturation to 32 bits, no clip flag
  always_comb begin
    if (q > Y_MAX_EXT) begin
      y_fb = Y_MAX_EXT[Y_W-1:0];
    end else if (q < Y_MIN_EXT) begin
      y_fb = Y_MIN_EXT[Y_W-1:0];
    end else begin
      y_fb = q[Y_W-1:0];
    end
  end

  // output saturation to the sample width
  always_comb begin
    clip = 1'b0;
    if (y_fb > OUT_MAX) begin
      y_out = OUT_MAX[SAMPLE_BITS-1:0];
      clip  = 1'b1;
    end else if (y_fb < OUT_MIN) begin
      y_out = OUT_MIN[SAMPLE_BITS-1:0];
      clip  = 1'b1;
    end else begin
      y_out = y_fb[SAMPLE_BITS-1:0];
    end
  end

endmodule
`default_nettype wire

@@ rtl/biquad_eq_filter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// biquad_eq_filter
// Direct-form-1 biquad over interleaved channels with per-channel history
// held in a small synchronous memory.
// ----------------------------------------------------------------------------
// An item passes three stages: history read, multiply, then sum, round,
// saturate and write-back into the output register. Items whose channels
// differ from the item just before are taken back to back while results are
// not held back; an item on the same history slot as the item just accepted
// waits, longer while results are held back, because its feedback values
// come from the history memory once the previous result for that slot has
// been written back (the write is forwarded into the read at that edge).
// A channel number at or above NUM_CHANNELS uses slot channel mod
// NUM_CHANNELS. History reads as zero after reset with no clearing pass.
module biquad_eq_filter #(
  parameter int NUM_CHANNELS    = bqeq_pkg::DEF_NUM_CHANNELS,
  parameter int SAMPLE_BITS     = bqeq_pkg::DEF_SAMPLE_BITS,
  parameter int COEFF_FRAC_BITS = bqeq_pkg::DEF_COEFF_FRAC_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0]      in_sample_in,
  input  wire logic                               in_channel,
  input  wire logic                               in_first_of_run,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic      signed [SAMPLE_BITS-1:0]      out_sample_out,
  output logic                                    out_channel_out,
  output logic                                    out_clipped,
  input  wire logic                               cfg_we,
  input  wire logic [bqeq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [bqeq_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import bqeq_pkg::*;

  localparam int SLOT_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int HIST_W = 2 * SAMPLE_BITS + 2 * Y_W;
  localparam logic signed [Y_W-1:0] OUT_MAX = 32'sh7FFF_FFFF >>> (Y_W - SAMPLE_BITS);

  coef_set_t coef;

  logic [SLOT_W-1:0] in_slot;
  logic              in_acc;
  logic              hazard;

  logic                          s1_valid_r, s1_valid_nxt;
  logic [SLOT_W-1:0]             s1_slot_r;
  logic                          s1_ch_r;
  logic                          s1_first_r;
  logic signed [SAMPLE_BITS-1:0] s1_x0_r;
  logic                          s1_adv;

  logic                          s2_valid_r, s2_valid_nxt;
  logic [SLOT_W-1:0]             s2_slot_r;
  logic                          s2_ch_r;
  logic signed [SAMPLE_BITS-1:0] s2_x0_r;
  logic signed [SAMPLE_BITS-1:0] s2_x1_r;
  logic signed [Y_W-1:0]         s2_y1_r;
  logic                          s2_adv;

  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic                          out_ch_r;
  logic                          out_clip_r;

  logic [HIST_W-1:0]             hist_rd;
  logic [HIST_W-1:0]             hist_eff;
  logic [HIST_W-1:0]             hist_wr;
  logic signed [SAMPLE_BITS-1:0] h_x1, h_x2;
  logic signed [Y_W-1:0]         h_y1, h_y2;

  logic signed [Y_W-1:0]         y_fb;
  logic signed [SAMPLE_BITS-1:0] y_out;
  logic                          y_clip;

  // coefficient registers
  bqeq_coef_regs u_coef (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .coef      (coef)
  );

  // slot of the incoming item
  assign in_slot = (NUM_CHANNELS > 1) ? SLOT_W'(in_channel) : '0;

  // pipeline advance
  assign s2_adv = s2_valid_r && (!out_valid_r || out_ready);
  assign s1_adv = s1_valid_r && (!s2_valid_r || s2_adv);

  // interlock: the slot must not be pending in a stage that has not written
  assign hazard = (s1_valid_r && (s1_slot_r == in_slot)) ||
                  (s2_valid_r && (s2_slot_r == in_slot) && !s2_adv);
  assign in_ready = (!s1_valid_r || s1_adv) && !hazard;
  assign in_acc   = in_valid && in_ready;

  // history memory, written back as the result leaves the sum stage
  assign hist_wr = {s2_x0_r, s2_x1_r, y_fb, s2_y1_r};

  bqeq_hist_mem #(
    .DEPTH (NUM_CHANNELS),
    .AW    (SLOT_W),
    .DW    (HIST_W)
  ) u_hist (
    .clk   (clk),
    .rst_n (rst_n),
    .re    (in_acc),
    .raddr (in_slot),
    .rdata (hist_rd),
    .we    (s2_adv),
    .waddr (s2_slot_r),
    .wdata (hist_wr)
  );

  // history operands, cleared at the start of a run
  always_comb begin
    hist_eff = s1_first_r ? '0 : hist_rd;
    h_x1 = $signed(hist_eff[HIST_W-1 -: SAMPLE_BITS]);
    h_x2 = $signed(hist_eff[HIST_W-SAMPLE_BITS-1 -: SAMPLE_BITS]);
    h_y1 = $signed(hist_eff[2*Y_W-1 -: Y_W]);
    h_y2 = $signed(hist_eff[Y_W-1:0]);
  end

  // multiply and accumulate unit
  bqeq_mac #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
  ) u_mac (
    .clk   (clk),
    .en    (s1_adv),
    .coef  (coef),
    .x0    (s1_x0_r),
    .x1    (h_x1),
    .x2    (h_x2),
    .y1    (h_y1),
    .y2    (h_y2),
    .y_fb  (y_fb),
    .y_out (y_out),
    .clip  (y_clip)
  );

  // stage valid next values
  always_comb begin
    s1_valid_nxt = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    s2_valid_nxt = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_valid_r);
    out_valid_nxt = s2_adv ? 1'b1 : ((out_valid_r && out_ready) ? 1'b0 : out_valid_r);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // read stage payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_slot_r  <= in_slot;
      s1_ch_r    <= in_channel;
      s1_first_r <= in_first_of_run;
      s1_x0_r    <= in_sample_in;
    end
  end

  // multiply stage payload, kept for the write-back
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_slot_r <= s1_slot_r;
      s2_ch_r   <= s1_ch_r;
      s2_x0_r   <= s1_x0_r;
      s2_x1_r   <= h_x1;
      s2_y1_r   <= h_y1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (s2_adv) begin
      out_sample_r <= y_out;
      out_ch_r     <= s2_ch_r;
      out_clip_r   <= y_clip;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sample_out  = out_sample_r;
  assign out_channel_out = out_ch_r;
  assign out_clipped     = out_clip_r;

  // two stages never hold the same slot
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s2_valid_r |-> s1_slot_r != s2_slot_r)
    else $error("same history slot in read and multiply stages");

  // a stalled sum stage keeps its item
  assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && !s2_adv |=> s2_valid_r && $stable(s2_slot_r))
    else $error("sum stage item lost while stalled");

  // a new result only comes out of the sum stage
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r ##1 out_valid_r |-> $past(s2_valid_r))
    else $error("result without an item in the sum stage");

  // a clipped result sits at a rail
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_clip_r |->
      (out_sample_r == OUT_MAX[SAMPLE_BITS-1:0]) ||
      (out_sample_r == ~OUT_MAX[SAMPLE_BITS-1:0]))
    else $error("clip flag set on an unsaturated sample");

endmodule
`default_nettype wire

@@ bench/biquad_eq_filter_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_eq_filter_test
// Self-checking bench for the two-channel biquad filter. Filtered samples are
// predicted in exact wide arithmetic from a private copy of the coefficients
// and per-channel history, then compared field by field in arrival order.
// Directed items cover sample extremes, history clears, feedback overflow and
// ignored register writes; random phases reload the coefficients between runs.
// ----------------------------------------------------------------------------
module biquad_eq_filter_test;
  import bqeq_pkg::*;

  localparam int NUM_CH      = DEF_NUM_CHANNELS;
  localparam int SAMPLE_BITS = DEF_SAMPLE_BITS;
  localparam int FRAC_BITS   = DEF_COEFF_FRAC_BITS;
  localparam int NUM_COEFS   = 5;

  // register indexes past the last coefficient, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam int RAND_PHASES     = 7;
  localparam int ITEMS_PER_PHASE = 190;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEFF_W-1:0] coef_t;

  typedef struct packed {
    sample_t sample;
    logic    channel;
    logic    clipped;
  } filtered_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam coef_t   COEF_MAX   = 32'sh7FFF_FFFF;
  localparam coef_t   COEF_MIN   = 32'sh8000_0000;

  // exact filter arithmetic and 24-bit output prediction
  class biquad_scoreboard;
    coef_t            coef [NUM_COEFS];
    sample_t          x1 [NUM_CH];
    sample_t          x2 [NUM_CH];
    logic signed [Y_W-1:0] y1 [NUM_CH];
    logic signed [Y_W-1:0] y2 [NUM_CH];
    filtered_t        expected_q [$];
    int               fails;
    int               checked;
    int               clip_count;

    function new();
      coef[REG_B0] = B0_RESET;
      coef[REG_B1] = '0;
      coef[REG_B2] = '0;
      coef[REG_A1] = '0;
      coef[REG_A2] = '0;
      for (int i = 0; i < NUM_CH; i++) begin
        x1[i] = '0;
        x2[i] = '0;
        y1[i] = '0;
        y2[i] = '0;
      end
      fails      = 0;
      checked    = 0;
      clip_count = 0;
    endfunction

    function void write_coef(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx <= REG_A2) begin
        coef[idx] = value;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_input(sample_t x0, logic ch, logic clear);
      int slot;
      logic signed [79:0] acc;
      logic signed [Y_W-1:0] y;
      filtered_t res;
      slot = ch % NUM_CH;
      if (clear) begin
        x1[slot] = '0;
        x2[slot] = '0;
        y1[slot] = '0;
        y2[slot] = '0;
      end
      // exact sum, half rounds up, then floor shift
      acc = coef[REG_B0] * x0 + coef[REG_B1] * x1[slot] + coef[REG_B2] * x2[slot]
            - coef[REG_A1] * y1[slot] - coef[REG_A2] * y2[slot]
            + (80'sd1 <<< (FRAC_BITS - 1));
      acc = acc >>> FRAC_BITS;
      // feedback value saturates silently to 32 bits
      if (acc > 80'sh7FFF_FFFF) begin
        y = 32'sh7FFF_FFFF;
      end else if (acc < -80'sh8000_0000) begin
        y = 32'sh8000_0000;
      end else begin
        y = acc[Y_W-1:0];
      end
      res.channel = ch;
      res.clipped = 1'b0;
      if (y > SAMPLE_MAX) begin
        res.sample  = SAMPLE_MAX;
        res.clipped = 1'b1;
      end else if (y < SAMPLE_MIN) begin
        res.sample  = SAMPLE_MIN;
        res.clipped = 1'b1;
      end else begin
        res.sample = y[SAMPLE_BITS-1:0];
      end
      x2[slot] = x1[slot];
      x1[slot] = x0;
      y2[slot] = y1[slot];
      y1[slot] = y;
      expected_q.push_back(res);
    endfunction

    function void check_result(sample_t sample, logic ch, logic clipped);
      filtered_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected filtered item: sample_out %0d channel_out %0d", sample, ch);
        fails++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (clipped) clip_count++;
      if (sample !== want.sample) begin
        $error("sample_out: expected %0d, got %0d", want.sample, sample);
        fails++;
      end
      if (ch !== want.channel) begin
        $error("channel_out: expected %0d, got %0d", want.channel, ch);
        fails++;
      end
      if (clipped !== want.clipped) begin
        $error("clipped: expected %0d, got %0d", want.clipped, clipped);
        fails++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  sample_t in_sample_in = '0;
  logic in_channel = 1'b0;
  logic in_first_of_run = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  sample_t out_sample_out;
  logic out_channel_out;
  logic out_clipped;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  biquad_scoreboard sb = new();
  int   sent = 0;
  int   coef_sets = 1;
  int   sink_idle = 0;
  logic calm = 1'b0;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  biquad_eq_filter dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample_in    (in_sample_in),
    .in_channel      (in_channel),
    .in_first_of_run (in_first_of_run),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_sample_out  (out_sample_out),
    .out_channel_out (out_channel_out),
    .out_clipped     (out_clipped),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  // watch every handshake and register write
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        sb.write_coef(cfg_index, cfg_wdata);
      end
      if (in_valid && in_ready) begin
        sb.note_input(in_sample_in, in_channel, in_first_of_run);
      end
      if (out_valid && out_ready) begin
        sb.check_result(out_sample_out, out_channel_out, out_clipped);
      end
    end
  end

  // result sink, back-pressure in random bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (sink_idle > 0) begin
      sink_idle = sink_idle - 1;
      out_ready <= 1'b0;
    end else if (!calm && ($urandom_range(0, 5) == 0)) begin
      sink_idle = $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // present one item and hold it until accepted
  task automatic send_item(input sample_t x, input logic ch, input logic first);
    in_valid        <= 1'b1;
    in_sample_in    <= x;
    in_channel      <= ch;
    in_first_of_run <= first;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // sender idles with valid low
  task automatic idle_cycles(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // stop sending until every expected result has come back
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // one register write
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  // reload the whole coefficient set with nothing in flight
  task automatic load_coefs(input coef_t b0, input coef_t b1, input coef_t b2,
                            input coef_t a1, input coef_t a2);
    wait_drain();
    cfg_write(REG_B0, b0);
    cfg_write(REG_B1, b1);
    cfg_write(REG_B2, b2);
    cfg_write(REG_A1, a1);
    cfg_write(REG_A2, a2);
    cfg_we <= 1'b0;
    coef_sets++;
  endtask

  // random coefficients, odd phases scaled down towards stable filters
  task automatic random_coefs(input int phase);
    coef_t c [NUM_COEFS];
    for (int k = 0; k < NUM_COEFS; k++) begin
      c[k] = coef_t'($urandom());
      if (phase % 2 == 1) begin
        c[k] = c[k] >>> 3;
      end
    end
    load_coefs(c[REG_B0], c[REG_B1], c[REG_B2], c[REG_A1], c[REG_A2]);
  endtask

  // random item, extremes now and then, optional idle burst after it
  task automatic random_item(input logic quiet);
    sample_t x;
    logic    ch;
    logic    first;
    int      pick;
    pick  = $urandom_range(0, 15);
    ch    = 1'($urandom_range(0, 1));
    first = ($urandom_range(0, 15) == 0);
    if (pick == 0) begin
      x = SAMPLE_MAX;
    end else if (pick == 1) begin
      x = SAMPLE_MIN;
    end else begin
      x = sample_t'($urandom());
    end
    send_item(x, ch, first);
    if (!quiet && ($urandom_range(0, 5) == 0)) begin
      idle_cycles($urandom_range(1, 4));
    end
  endtask

  // stimulus
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset coefficients: unity pass-through, extremes on both channels
    for (int c = 0; c < NUM_CH; c++) begin
      send_item(SAMPLE_MAX, 1'(c), 1'b1);
      send_item(SAMPLE_MIN, 1'(c), 1'b0);
      send_item('0, 1'(c), 1'b0);
      send_item(-24'sd1, 1'(c), 1'b0);
      send_item(24'sd1, 1'(c), 1'b0);
      send_item(SAMPLE_MAX, 1'(c), 1'b0);
    end

    // gain of two with a little smoothing: output clipping
    load_coefs(32'sh2000_0000, 32'sh0800_0000, '0, '0, '0);
    for (int i = 0; i < 24; i++) begin
      send_item((i % 4 < 2) ? SAMPLE_MAX : SAMPLE_MIN, 1'(i), (i < 2));
    end

    // runaway feedback: 32-bit saturation of the stored history
    load_coefs(COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX);
    for (int i = 0; i < 30; i++) begin
      send_item((i < 15) ? SAMPLE_MAX : SAMPLE_MIN, 1'(i / 15), (i == 0));
    end
    for (int i = 0; i < 10; i++) begin
      send_item('0, 1'(i), (i < 2));
    end

    // writes past the last register change nothing
    wait_drain();
    cfg_write(REG_SPARE_LO, $urandom());
    cfg_write(REG_SPARE_HI, $urandom());
    cfg_we <= 1'b0;
    for (int i = 0; i < 20; i++) begin
      random_item(1'b0);
    end

    // random coefficient sets, the last one with no idling at all
    for (int p = 0; p < RAND_PHASES; p++) begin
      random_coefs(p);
      if (p == RAND_PHASES - 1) begin
        calm = 1'b1;
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        random_item(calm);
      end
    end

    wait_drain();
    $display("covered %0d items under %0d coefficient sets, %0d of them clipped,",
             sb.checked, coef_sets, sb.clip_count);
    $display("with history clears, feedback saturation, dropped writes and stalls");
    if (sb.fails == 0 && sb.checked == sent) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $error("run limit reached with %0d results outstanding", sb.pending());
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ bench/biquad_eq_filter_test_top.sv @@
`timescale 1ns / 1ps
